>>> design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants and types for the projection profile score block.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  // fixed field widths
  localparam int WORD_BITS  = 32;
  localparam int CFG_BITS   = 14;
  localparam int OUT_BITS   = 48;

  // sizing
  localparam int MAX_WIDTH  = 8192;
  localparam int SCORE_BITS = 48;

  // derived widths
  localparam int WORD_SHIFT = $clog2(WORD_BITS);
  localparam int POS_BITS   = $clog2(MAX_WIDTH / WORD_BITS);
  localparam int LAST_BITS  = CFG_BITS - WORD_SHIFT;
  localparam int COUNT_BITS = $clog2(MAX_WIDTH + 1);
  localparam int PC_BITS    = $clog2(WORD_BITS + 1);
  localparam int SQ_BITS    = 2 * COUNT_BITS;

  // row stage to score stage transaction
  typedef struct packed {
    logic                  valid;
    logic                  add_en;
    logic                  eoi;
    logic [COUNT_BITS-1:0] diff;
  } row_xfer_t;

endpackage

`default_nettype wire

>>> design/pps_row_stage.sv
// ----------------------------------------------------------------------------
// pps_row_stage
// Masks and counts each word, closes rows, and registers the absolute
// count difference for pairs of consecutive text rows.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_row_stage import pps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [CFG_BITS-1:0]  image_width,
  input  wire logic                 word_valid,
  input  wire logic [WORD_BITS-1:0] pixel_word,
  input  wire logic                 end_of_image,
  output logic                      word_take,
  output row_xfer_t                 xfer,
  input  wire logic                 xfer_take
);

  // popcount as a tree of pairwise field sums
  function automatic logic [PC_BITS-1:0] count_ones(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] s2;
    logic [WORD_BITS-1:0] s4;
    logic [WORD_BITS-1:0] s8;
    logic [WORD_BITS-1:0] s16;
    logic [WORD_BITS-1:0] s32;
    s2  = (v & 32'h5555_5555) + ((v >> 1) & 32'h5555_5555);
    s4  = (s2 & 32'h3333_3333) + ((s2 >> 2) & 32'h3333_3333);
    s8  = (s4 & 32'h0F0F_0F0F) + ((s4 >> 4) & 32'h0F0F_0F0F);
    s16 = (s8 & 32'h00FF_00FF) + ((s8 >> 8) & 32'h00FF_00FF);
    s32 = (s16 & 32'h0000_FFFF) + ((s16 >> 16) & 32'h0000_FFFF);
    return s32[PC_BITS-1:0];
  endfunction

  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] row_cnt_r, row_cnt_nxt;
  logic [COUNT_BITS-1:0] prev_cnt_r, prev_cnt_nxt;
  logic                  prev_text_r, prev_text_nxt;
  row_xfer_t             xfer_r, xfer_nxt;

  logic [CFG_BITS-1:0]   w_eff;
  logic [CFG_BITS-1:0]   w_m1;
  logic [LAST_BITS-1:0]  last_idx;
  logic                  at_last;
  logic [WORD_BITS-1:0]  mask;
  logic [WORD_BITS-1:0]  word_m;
  logic [COUNT_BITS-1:0] cnt_sum;
  logic                  row_close;
  logic                  is_text;
  logic [COUNT_BITS-1:0] diff;

  // effective width clamped to one through the maximum
  always_comb begin
    if (image_width == '0) begin
      w_eff = CFG_BITS'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = CFG_BITS'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
  end

  // last word position and last word mask
  assign w_m1     = w_eff - CFG_BITS'(1);
  assign last_idx = w_m1[CFG_BITS-1:WORD_SHIFT];
  assign at_last  = LAST_BITS'(pos_r) >= last_idx;
  assign mask     = {WORD_BITS{1'b1}}
                    << (WORD_SHIFT'(WORD_BITS - 1) - w_m1[WORD_SHIFT-1:0]);
  assign word_m   = at_last ? (pixel_word & mask) : pixel_word;

  // row count, text decision and difference to the previous row
  assign cnt_sum   = row_cnt_r + COUNT_BITS'(count_ones(word_m));
  assign row_close = at_last || end_of_image;
  assign is_text   = cnt_sum < (w_eff >> 1);
  assign diff      = (cnt_sum > prev_cnt_r) ? (cnt_sum - prev_cnt_r)
                                            : (prev_cnt_r - cnt_sum);

  // handshake toward the score stage
  assign word_take = word_valid && (!xfer_r.valid || xfer_take);

  // row state update
  always_comb begin
    pos_nxt       = pos_r;
    row_cnt_nxt   = row_cnt_r;
    prev_cnt_nxt  = prev_cnt_r;
    prev_text_nxt = prev_text_r;
    if (word_take) begin
      if (row_close) begin
        prev_cnt_nxt  = cnt_sum;
        prev_text_nxt = is_text;
        row_cnt_nxt   = '0;
        pos_nxt       = '0;
      end else begin
        row_cnt_nxt = cnt_sum;
        pos_nxt     = pos_r + POS_BITS'(1);
      end
      if (end_of_image) begin
        prev_cnt_nxt  = '0;
        prev_text_nxt = 1'b0;
      end
    end
  end

  // stage register
  always_comb begin
    xfer_nxt = xfer_r;
    if (word_take) begin
      xfer_nxt.valid  = 1'b1;
      xfer_nxt.add_en = row_close && is_text && prev_text_r;
      xfer_nxt.eoi    = end_of_image;
      xfer_nxt.diff   = diff;
    end else if (xfer_take) begin
      xfer_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      row_cnt_r   <= '0;
      prev_cnt_r  <= '0;
      prev_text_r <= 1'b0;
      xfer_r      <= '0;
    end else begin
      pos_r       <= pos_nxt;
      row_cnt_r   <= row_cnt_nxt;
      prev_cnt_r  <= prev_cnt_nxt;
      prev_text_r <= prev_text_nxt;
      xfer_r      <= xfer_nxt;
    end
  end

  assign xfer = xfer_r;

endmodule

`default_nettype wire

>>> design/pps_score_stage.sv
// ----------------------------------------------------------------------------
// pps_score_stage
// Squares the row difference, adds it into the saturating score and
// holds the finished score in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_score_stage import pps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire row_xfer_t             xfer,
  output logic                       xfer_take,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_BITS-1:0]        out_profile_score,
  output logic                       out_score_saturated
);

  localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

  logic                  sq_valid_r, sq_valid_nxt;
  logic                  sq_add_r;
  logic                  sq_eoi_r;
  logic [SQ_BITS-1:0]    sq_r;
  logic [SCORE_BITS-1:0] acc_r, acc_nxt;
  logic                  sat_r, sat_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic [SCORE_BITS-1:0] res_score_r;
  logic                  res_sat_r;

  logic                  out_free;
  logic                  sq_take;
  logic [SCORE_BITS:0]   sum;
  logic [SCORE_BITS-1:0] acc_upd;
  logic                  sat_upd;

  // stage handshakes
  assign out_free  = !res_valid_r || !out_stall;
  assign sq_take   = sq_valid_r && (!sq_eoi_r || out_free);
  assign xfer_take = xfer.valid && (!sq_valid_r || sq_take);

  // square register
  assign sq_valid_nxt = xfer_take ? 1'b1 : (sq_take ? 1'b0 : sq_valid_r);

  always_ff @(posedge clk) begin
    if (xfer_take) begin
      sq_r     <= SQ_BITS'(xfer.diff) * SQ_BITS'(xfer.diff);
      sq_add_r <= xfer.add_en;
      sq_eoi_r <= xfer.eoi;
    end
  end

  // saturating accumulate
  assign sum = {1'b0, acc_r} + (SCORE_BITS + 1)'(sq_r);

  always_comb begin
    acc_upd = acc_r;
    sat_upd = sat_r;
    if (sq_add_r) begin
      if (sum[SCORE_BITS]) begin
        acc_upd = SCORE_MAX;
        sat_upd = 1'b1;
      end else begin
        acc_upd = sum[SCORE_BITS-1:0];
      end
    end
  end

  // accumulator clears when the score moves into the result register
  always_comb begin
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    if (sq_take) begin
      if (sq_eoi_r) begin
        acc_nxt = '0;
        sat_nxt = 1'b0;
      end else begin
        acc_nxt = acc_upd;
        sat_nxt = sat_upd;
      end
    end
  end

  // result register
  assign res_valid_nxt = (res_valid_r && out_stall) || (sq_take && sq_eoi_r);

  always_ff @(posedge clk) begin
    if (sq_take && sq_eoi_r) begin
      res_score_r <= acc_upd;
      res_sat_r   <= sat_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r  <= 1'b0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      sq_valid_r  <= sq_valid_nxt;
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign out_valid           = res_valid_r;
  assign out_profile_score   = OUT_BITS'(res_score_r);
  assign out_score_saturated = res_sat_r;

endmodule

`default_nettype wire

>>> design/projection_profile_score_top.sv
// ----------------------------------------------------------------------------
// projection_profile_score_top
// Horizontal projection profile score of a bilevel image streamed as
// 32-bit words, one score per image.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  in       | in_valid / in_stall        | in_pixel_word, in_end_of_image
//  out      | out_valid / out_stall      | out_profile_score,
//           |                            | out_score_saturated
//  cfg      | cfg_wr_en                  | cfg_wr_data (image width)
//
//  one word is accepted every cycle unless in_stall holds it; the input
//  register, row stage, square register and accumulator are its stages
//  the score shows on out from the result register, after the square register
//  out_stall backs the pipeline up only while an end-of-image transaction
//  waits behind a held result
//  synchronous reset clears all row and score state, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module projection_profile_score_top import pps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [WORD_BITS-1:0] in_pixel_word,
  input  wire logic                 in_end_of_image,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_BITS-1:0]       out_profile_score,
  output logic                      out_score_saturated,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_BITS-1:0]  cfg_wr_data
);

  logic [CFG_BITS-1:0]  width_r;
  logic                 in_valid_r, in_valid_nxt;
  logic [WORD_BITS-1:0] in_word_r;
  logic                 in_eoi_r;
  logic                 in_take;
  logic                 word_take;
  logic                 xfer_take;
  row_xfer_t            xfer;

  // width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CFG_BITS'(MAX_WIDTH);
    end else if (cfg_wr_en) begin
      width_r <= cfg_wr_data;
    end
  end

  // input register
  assign in_stall     = in_valid_r && !word_take;
  assign in_take      = in_valid && !in_stall;
  assign in_valid_nxt = in_take || (in_valid_r && !word_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_pixel_word;
      in_eoi_r  <= in_end_of_image;
    end
  end

  // row counting stage
  pps_row_stage u_row (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .word_valid   (in_valid_r),
    .pixel_word   (in_word_r),
    .end_of_image (in_eoi_r),
    .word_take    (word_take),
    .xfer         (xfer),
    .xfer_take    (xfer_take)
  );

  // square, accumulate and result stage
  pps_score_stage u_score (
    .clk                 (clk),
    .rst_n               (rst_n),
    .xfer                (xfer),
    .xfer_take           (xfer_take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_profile_score   (out_profile_score),
    .out_score_saturated (out_score_saturated)
  );

endmodule

`default_nettype wire

>>> design/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks on the result channel of the projection profile
// score block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_checker import pps_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [OUT_BITS-1:0] out_profile_score,
  input wire logic                out_score_saturated
);

  localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

  // a held result keeps its valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_profile_score)
                               && $stable(out_score_saturated))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a clamped score is the full-scale value
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_score_saturated |-> out_profile_score == OUT_BITS'(SCORE_MAX))
    else $error("saturated score is not at maximum");

endmodule

bind projection_profile_score_top pps_checker u_pps_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_profile_score   (out_profile_score),
  .out_score_saturated (out_score_saturated)
);

`default_nettype wire

>>> bench/projection_profile_score_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projection_profile_score_top_test
// Self-checking bench for the projection profile score block. Streams
// bilevel images as pixel words under several image widths, predicts each
// image score in a scoreboard and compares every result field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [pps_pkg::OUT_BITS-1:0] score;
  logic                         saturated;
} profile_result_t;

// row profile predictor and the queue of scores still owed by the block
class score_tracker_t;
  logic [pps_pkg::CFG_BITS-1:0] width_reg;
  int unsigned                  word_pos;
  int unsigned                  row_count;
  int unsigned                  prev_count;
  bit                           prev_text;
  logic [63:0]                  acc;
  bit                           sat;
  profile_result_t              pending_scores[$];
  int unsigned                  mismatches;

  function new();
    width_reg  = 14'd8192;
    mismatches = 0;
    clear_image();
  endfunction

  function void clear_image();
    word_pos   = 0;
    row_count  = 0;
    prev_count = 0;
    prev_text  = 1'b0;
    acc        = '0;
    sat        = 1'b0;
  endfunction

  function void set_width(logic [pps_pkg::CFG_BITS-1:0] value);
    width_reg = value;
  endfunction

  // width clamped to 1..MAX_WIDTH
  function int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > pps_pkg::MAX_WIDTH) w = pps_pkg::MAX_WIDTH;
    return w;
  endfunction

  function int unsigned row_words();
    return ((eff_width() - 1) >> 5) + 1;
  endfunction

  // one accepted input transaction
  function void absorb_word(logic [31:0] word, logic eoi);
    int unsigned     w;
    int unsigned     last_idx;
    int unsigned     keep;
    int unsigned     diff;
    logic [31:0]     masked;
    logic [63:0]     sq;
    logic [63:0]     top;
    bit              at_last;
    bit              is_text;
    profile_result_t res;
    w        = eff_width();
    last_idx = (w - 1) >> 5;
    at_last  = word_pos >= last_idx;
    masked   = word;
    if (at_last) begin
      keep   = 31 - ((w - 1) & 31);
      masked = word & (32'hFFFF_FFFF << keep);
    end
    row_count += $countones(masked);

    // row closes on its last word or on end of image
    if (at_last || eoi) begin
      is_text = row_count < (w / 2);
      if (is_text && prev_text) begin
        diff = (row_count > prev_count) ? row_count - prev_count : prev_count - row_count;
        sq   = 64'(diff) * 64'(diff);
        top  = (64'd1 << pps_pkg::SCORE_BITS) - 64'd1;
        if (acc > top || sq > top - acc) begin
          acc = top;
          sat = 1'b1;
        end else begin
          acc += sq;
        end
      end
      prev_count = row_count;
      prev_text  = is_text;
      row_count  = 0;
      word_pos   = 0;
    end else begin
      word_pos++;
    end

    if (eoi) begin
      res.score     = acc[pps_pkg::OUT_BITS-1:0];
      res.saturated = sat;
      pending_scores.push_back(res);
      clear_image();
    end
  endfunction

  // one accepted result transaction
  function void check_score(logic [pps_pkg::OUT_BITS-1:0] score, logic saturated);
    profile_result_t want;
    if (pending_scores.size() == 0) begin
      $error("unexpected result: profile_score=%0d score_saturated=%0b", score, saturated);
      mismatches++;
      return;
    end
    want = pending_scores.pop_front();
    if (score !== want.score) begin
      $error("profile_score: expected %0d, actual %0d", want.score, score);
      mismatches++;
    end
    if (saturated !== want.saturated) begin
      $error("score_saturated: expected %0b, actual %0b", want.saturated, saturated);
      mismatches++;
    end
  endfunction
endclass

module projection_profile_score_top_test import pps_pkg::*; ();

  // watchdog bound, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // input register, row stage, square and accumulator plus margin
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 1430;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef enum int {
    FILL_BLANK,
    FILL_SOLID,
    FILL_SPARSE,
    FILL_HALF,
    FILL_DENSE
  } fill_style_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [WORD_BITS-1:0] in_pixel_word;
  logic                 in_end_of_image;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_BITS-1:0]  out_profile_score;
  logic                 out_score_saturated;
  logic                 cfg_wr_en;
  logic [CFG_BITS-1:0]  cfg_wr_data;

  score_tracker_t tracker = new();

  int unsigned send_idle_pct  = 12;
  int unsigned recv_stall_pct = 54;
  int unsigned hold_request   = 0;
  int unsigned accepted_words = 0;

  projection_profile_score_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_word       (in_pixel_word),
    .in_end_of_image     (in_end_of_image),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_profile_score   (out_profile_score),
    .out_score_saturated (out_score_saturated),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one word until the block takes it
  task automatic send_word(input logic [31:0] word, input logic eoi);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_pixel_word   = word;
    in_end_of_image = eoi;
    do @(posedge clk); while (in_stall);
    tracker.absorb_word(word, eoi);
    accepted_words++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // quiet input, all scores back, pipeline flushed
  task automatic wait_scores_drained();
    idle_input();
    while (tracker.pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_BITS-1:0] value);
    wait_scores_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    tracker.set_width(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [31:0] pixel_pattern(fill_style_t style);
    case (style)
      FILL_BLANK:  return 32'h0;
      FILL_SOLID:  return 32'hFFFF_FFFF;
      FILL_SPARSE: return $urandom & $urandom & $urandom;
      FILL_HALF:   return $urandom;
      default:     return $urandom | $urandom;
    endcase
  endfunction

  // mostly light rows so that text rows follow one another
  function automatic fill_style_t pick_style();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return FILL_SPARSE;
    if (r < 50) return FILL_BLANK;
    if (r < 70) return FILL_HALF;
    if (r < 85) return FILL_DENSE;
    return FILL_SOLID;
  endfunction

  // small widths dominate, word and range edges, a few full-size rows
  function automatic logic [CFG_BITS-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return CFG_BITS'($urandom_range(1, 64));
    if (r < 70) begin
      case ($urandom_range(0, 10))
        0:       return 14'd0;
        1:       return 14'd1;
        2:       return 14'd2;
        3:       return 14'd31;
        4:       return 14'd32;
        5:       return 14'd33;
        6:       return 14'd63;
        7:       return 14'd64;
        8:       return 14'd65;
        9:       return 14'd96;
        default: return 14'd97;
      endcase
    end
    if (r < 92) return CFG_BITS'($urandom_range(65, 600));
    if (r < 96) return CFG_BITS'($urandom_range(601, 8192));
    case ($urandom_range(0, 3))
      0:       return 14'd8192;
      1:       return 14'd8193;
      2:       return 14'd16383;
      default: return CFG_BITS'($urandom_range(8193, 16383));
    endcase
  endfunction

  // rows of one image, end of image on the last word or cut short mid-row
  task automatic send_image(input int unsigned rows, input bit broken);
    int unsigned wpr;
    int unsigned cut;
    fill_style_t style;
    bit          eoi;
    wpr = tracker.row_words();
    cut = broken ? $urandom_range(0, wpr - 1) : wpr - 1;
    for (int unsigned r = 0; r < rows; r++) begin
      style = pick_style();
      for (int unsigned i = 0; i < wpr; i++) begin
        eoi = (r == rows - 1) && (i == cut);
        send_word(pixel_pattern(style), eoi);
        if (eoi) break;
      end
    end
  endtask

  // long output hold while images keep coming, then full drain
  task automatic backpressure_burst();
    write_width(14'd8);
    @(negedge clk);
    hold_request = HOLD_CYCLES;
    repeat (60) send_word(pixel_pattern(pick_style()), $urandom_range(0, 2) == 0);
    send_word(32'h0000_0001, 1'b1);
    wait_scores_drained();
  endtask

  // result side: random or held stall, check each accepted transaction
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = $urandom_range(99) < recv_stall_pct;
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.check_score(out_profile_score, out_score_saturated);
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[projection_profile_score_top] ERROR");
    $finish;
  end

  // main stimulus
  initial begin : stimulus
    int unsigned random_start;
    int unsigned progress;
    int unsigned wpr;
    int unsigned kind;
    bit          pressure_done;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_pixel_word   = '0;
    in_end_of_image = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    pressure_done   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset width, end of image on the first word of a long row
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0000, 1'b1);

    // one-pixel rows, nothing counts as text
    write_width(14'd1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b1);

    // zero width acts as one
    write_width(14'd0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b1);

    // two-word rows with a one-bit last word, image ends mid-row
    write_width(14'd33);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'hC000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_FFFF, 1'b1);

    // width shrinks mid-row, the next word closes the row
    send_word(32'h0000_0001, 1'b0);
    write_width(14'd32);
    send_word(32'h0000_0003, 1'b0);
    send_word(32'h0000_00FF, 1'b1);

    // widths above the maximum clamp to it
    write_width(14'd16383);
    send_word(32'hAAAA_AAAA, 1'b1);
    write_width(14'd8193);
    send_word(32'h5555_5555, 1'b1);

    // random phases: new width, then a few images
    random_start = accepted_words;
    while (accepted_words - random_start < RANDOM_ITEMS) begin
      progress = accepted_words - random_start;
      if (progress < RANDOM_ITEMS / 3) begin
        send_idle_pct  = 12;
        recv_stall_pct = 54;
      end else if (progress < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 54;
        recv_stall_pct = 12;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        if (!pressure_done) begin
          backpressure_burst();
          pressure_done = 1'b1;
        end
      end

      write_width(pick_width());
      wpr = tracker.row_words();
      repeat ((wpr > 32) ? 1 : $urandom_range(1, 4)) begin
        kind = $urandom_range(99);
        if (kind < 80) begin
          send_image((wpr > 32) ? $urandom_range(1, 2) : $urandom_range(1, 10), 1'b0);
        end else if (kind < 90) begin
          send_image((wpr > 32) ? 1 : $urandom_range(1, 6), 1'b1);
        end else begin
          repeat ($urandom_range(1, 6)) send_word($urandom, $urandom_range(0, 3) == 0);
        end
      end
      // sometimes leave a row open across the width change
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, wpr)) send_word(pixel_pattern(pick_style()), 1'b0);
      end
    end

    // close any open row so its score comes back
    send_word(32'h0000_0000, 1'b1);
    wait_scores_drained();
    if (tracker.mismatches == 0 && tracker.pending_scores.size() == 0) begin
      $display("[projection_profile_score_top] OK");
    end else begin
      $display("[projection_profile_score_top] ERROR");
    end
    $finish;
  end

endmodule
